### rtl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, constants and helpers for the prefix varint codec: opcode
// encoding, offset sum and the per-length base offsets of the bijective code.
// ----------------------------------------------------------------------------
package pvc_pkg;

  // item operation carried in the input tuser
  typedef enum logic [1:0] {
    OP_ENC_U = 2'd0,
    OP_ENC_S = 2'd1,
    OP_DEC_U = 2'd2,
    OP_DEC_S = 2'd3
  } pvc_op_e;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 72;   // longest code: nine bytes
  localparam int unsigned LenW    = 4;
  localparam int unsigned MaxLen  = 9;

  // sum of 2^(7k) for k = 1..8
  localparam logic [ValueW-1:0] SumOffset = 64'h0102_0408_1020_4080;

  // offset subtracted from unsigned values coded in n bytes
  function automatic logic [ValueW-1:0] base_of(input logic [LenW-1:0] n);
    logic [ValueW-1:0] b;
    unique case (n)
      4'd0, 4'd1: b = 64'h0000_0000_0000_0000;
      4'd2:       b = 64'h0000_0000_0000_0080;
      4'd3:       b = 64'h0000_0000_0000_4080;
      4'd4:       b = 64'h0000_0000_0020_4080;
      4'd5:       b = 64'h0000_0000_1020_4080;
      4'd6:       b = 64'h0000_0008_1020_4080;
      4'd7:       b = 64'h0000_0408_1020_4080;
      4'd8:       b = 64'h0002_0408_1020_4080;
      default:    b = SumOffset;
    endcase
    return b;
  endfunction

endpackage

### rtl/prefix_varint_codec.sv
// ----------------------------------------------------------------------------
// prefix_varint_codec
// 64-bit prefix varint encoder / decoder, unsigned (bijective) and signed.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis: one item per transfer. tuser is the opcode (encode
//   unsigned, encode signed, decode unsigned byte, decode signed byte), tdata
//   holds the value to encode and the next code byte to decode.
//   Master channel m_axis: an encode gives one transfer per code byte (1 to 9,
//   most significant first, tlast on the final one). A decode byte that
//   completes a code gives one transfer carrying the value with tlast set;
//   other decode bytes give nothing. Signedness of a decode is taken from the
//   first byte of its code; encodes may be interleaved with a pending decode.
//   Path: each result passes the input register, the job register and the
//   output register, in that order, before it is offered on m_axis.
//   Throughput: one decode byte per cycle while no encode is being emitted
//   and the receiver is ready; an encode holds the job register, and the next
//   item waits, until its last code byte is emitted.
//   Reset clears all valids and the decode state; no item is pending after.
//   When the receiver stalls, the output register holds, the job register
//   fills, then the input register fills and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module prefix_varint_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // value_in[63:0], byte_in[71:64]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // byte_out[7:0], value_out[71:8]
  output logic [2:0]  m_axis_tuser,   // byte_valid[0], value_valid[1], overflow[2]
  output logic        m_axis_tlast
);

  // input register
  logic                        in_valid_q, in_valid_d;
  pvc_pkg::pvc_op_e            in_op_q;
  logic [pvc_pkg::ValueW-1:0]  in_value_q;
  logic [pvc_pkg::ByteW-1:0]   in_byte_q;

  // job register: remaining results of one item
  logic                        job_valid_q, job_valid_d;
  logic [pvc_pkg::LenW-1:0]    job_cnt_q, job_cnt_d;
  logic [pvc_pkg::WordW-1:0]   job_word_q, job_word_d;
  logic                        job_dec_q, job_dec_d;
  logic [pvc_pkg::ValueW-1:0]  job_value_q, job_value_d;
  logic                        job_ovf_q, job_ovf_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [71:0]                 out_data_q;
  logic [2:0]                  out_user_q;
  logic                        out_last_q;

  // decode state
  logic [pvc_pkg::LenW-1:0]    bytes_left_q, bytes_left_d;
  logic [pvc_pkg::LenW-1:0]    code_length_q, code_length_d;
  logic                        dec_signed_q, dec_signed_d;
  logic [pvc_pkg::ValueW-1:0]  acc_q, acc_d;

  // handshake
  logic out_load, job_emit, job_last_emit, in_take, s_take;
  logic is_encode, dec_done, job_load;

  // encode path
  logic                        enc_signed;
  logic [pvc_pkg::ValueW-1:0]  enc_mag, enc_base, enc_pay;
  logic [pvc_pkg::LenW-1:0]    enc_n;
  logic [pvc_pkg::WordW-1:0]   enc_word;

  // decode path
  logic [pvc_pkg::ValueW-1:0]  dec_base, dec_value, dec_mask;
  logic [pvc_pkg::ValueW:0]    dec_sum;
  logic                        dec_ovf;

  assign out_load      = !out_valid_q || m_axis_tready;
  assign job_emit      = job_valid_q && out_load;
  assign job_last_emit = job_emit && (job_cnt_q == pvc_pkg::LenW'(1));
  assign in_take       = in_valid_q && (!job_valid_q || job_last_emit);
  assign s_axis_tready = !in_valid_q || in_take;
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign is_encode     = (in_op_q == pvc_pkg::OP_ENC_U) || (in_op_q == pvc_pkg::OP_ENC_S);

  // encode: pick the code length, then left-align the code in the word
  always_comb begin
    enc_signed = (in_op_q == pvc_pkg::OP_ENC_S);
    enc_mag    = in_value_q[63] ? ~in_value_q : in_value_q;
    enc_n      = pvc_pkg::LenW'(pvc_pkg::MaxLen);
    for (int k = 8; k >= 1; k--) begin
      if (enc_signed ? ((enc_mag >> (7 * k - 1)) == '0)
                     : (in_value_q < pvc_pkg::base_of(pvc_pkg::LenW'(k + 1)))) begin
        enc_n = pvc_pkg::LenW'(k);
      end
    end
    enc_base = enc_signed ? '0 : pvc_pkg::base_of(enc_n);
    enc_pay  = in_value_q - enc_base;
    // nine-byte form: zero prefix then eight raw bytes
    enc_word = {8'h00, enc_pay};
    for (int k = 1; k <= 8; k++) begin
      if (enc_n == pvc_pkg::LenW'(k)) begin
        enc_word = {8'h00, (enc_pay & ((64'd1 << (7 * k)) - 64'd1)) | (64'd1 << (7 * k))}
                   << (72 - 8 * k);
      end
    end
  end

  // decode: next state of the pending code
  always_comb begin
    if (bytes_left_q == '0) begin
      dec_signed_d  = (in_op_q == pvc_pkg::OP_DEC_S);
      code_length_d = pvc_pkg::LenW'(pvc_pkg::MaxLen);
      acc_d         = '0;
      // length from the position of the marker bit
      for (int k = 8; k >= 1; k--) begin
        if (in_byte_q[8 - k]) begin
          code_length_d = pvc_pkg::LenW'(k);
          acc_d         = 64'(in_byte_q & 8'((9'd1 << (8 - k)) - 9'd1));
        end
      end
      bytes_left_d = code_length_d - pvc_pkg::LenW'(1);
    end else begin
      dec_signed_d  = dec_signed_q;
      code_length_d = code_length_q;
      acc_d         = {acc_q[55:0], in_byte_q};
      bytes_left_d  = bytes_left_q - pvc_pkg::LenW'(1);
    end
    dec_done = (bytes_left_d == '0);
  end

  // decode: value of a completed code
  always_comb begin
    dec_base  = pvc_pkg::base_of(code_length_d);
    dec_sum   = {1'b0, acc_d} + {1'b0, dec_base};
    dec_ovf   = 1'b0;
    dec_mask  = '1;
    dec_value = dec_sum[63:0];
    if (code_length_d >= pvc_pkg::LenW'(pvc_pkg::MaxLen)) begin
      if (dec_signed_d) begin
        dec_value = acc_d;
      end else begin
        dec_ovf = dec_sum[64];
      end
    end else if (dec_signed_d) begin
      dec_value = acc_d;
      for (int k = 1; k <= 8; k++) begin
        if (code_length_d == pvc_pkg::LenW'(k)) begin
          dec_mask  = (64'd1 << (7 * k)) - 64'd1;
          dec_value = acc_d[7 * k - 1] ? (acc_d | ~dec_mask) : (acc_d & dec_mask);
        end
      end
    end
  end

  assign job_load = in_take && (is_encode || dec_done);

  // job register next state
  always_comb begin
    job_valid_d = job_valid_q;
    job_cnt_d   = job_cnt_q;
    job_word_d  = job_word_q;
    job_dec_d   = job_dec_q;
    job_value_d = job_value_q;
    job_ovf_d   = job_ovf_q;
    if (job_emit) begin
      job_cnt_d  = job_cnt_q - pvc_pkg::LenW'(1);
      job_word_d = job_word_q << pvc_pkg::ByteW;
      if (job_last_emit) begin
        job_valid_d = 1'b0;
      end
    end
    if (job_load) begin
      job_valid_d = 1'b1;
      if (is_encode) begin
        job_cnt_d   = enc_n;
        job_word_d  = enc_word;
        job_dec_d   = 1'b0;
        job_value_d = '0;
        job_ovf_d   = 1'b0;
      end else begin
        job_cnt_d   = pvc_pkg::LenW'(1);
        job_word_d  = '0;
        job_dec_d   = 1'b1;
        job_value_d = dec_value;
        job_ovf_d   = dec_ovf;
      end
    end
  end

  assign in_valid_d  = s_take || (in_valid_q && !in_take);
  assign out_valid_d = out_load ? job_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      job_valid_q   <= 1'b0;
      job_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      bytes_left_q  <= '0;
      code_length_q <= '0;
      dec_signed_q  <= 1'b0;
      acc_q         <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      job_valid_q <= job_valid_d;
      job_cnt_q   <= job_cnt_d;
      out_valid_q <= out_valid_d;
      if (in_take && !is_encode) begin
        bytes_left_q  <= bytes_left_d;
        code_length_q <= code_length_d;
        dec_signed_q  <= dec_signed_d;
        acc_q         <= acc_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_op_q    <= pvc_pkg::pvc_op_e'(s_axis_tuser);
      in_value_q <= s_axis_tdata[63:0];
      in_byte_q  <= s_axis_tdata[71:64];
    end
    job_word_q  <= job_word_d;
    job_dec_q   <= job_dec_d;
    job_value_q <= job_value_d;
    job_ovf_q   <= job_ovf_d;
    if (job_emit) begin
      out_data_q <= {job_value_q, job_word_q[71:64]};
      out_user_q <= {job_ovf_q, job_dec_q, !job_dec_q};
      out_last_q <= (job_cnt_q == pvc_pkg::LenW'(1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // a live job always has between one and nine results left
  a_job_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_cnt_q != '0) && (job_cnt_q <= pvc_pkg::LenW'(pvc_pkg::MaxLen)))
    else $error("job count out of range");

  // a pending code never has more than eight bytes to come
  a_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= pvc_pkg::LenW'(8))
    else $error("decode bytes_left out of range");

  // a decoded value is a single result and never carries a code byte
  a_value_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("decode result malformed");

  // overflow only on a decoded value
  a_ovf_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1])
    else $error("overflow without value");

endmodule

### tb/prefix_varint_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_codec_tb
// Drives encode and decode items into the prefix varint codec with bursty
// input and a stalling output side, works out every output transfer with an
// independent bit-accurate model of the code and compares them in order.
// ----------------------------------------------------------------------------
module prefix_varint_codec_tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandItems  = 256;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 12;

  // one output transfer as seen by the receiver
  typedef struct packed {
    logic [7:0]  code_byte;
    logic        byte_ok;
    logic [63:0] value;
    logic        value_ok;
    logic        wrapped;
    logic        final_xfer;
  } codec_xfer_t;

  typedef struct packed {
    pvc_pkg::pvc_op_e op;
    logic [63:0]      value;
    logic [7:0]       din;
    logic             typed;
    codec_xfer_t      want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // value_in[63:0], byte_in[71:64]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // byte_out[7:0], value_out[71:8]
  logic [2:0]  m_axis_tuser;        // byte_valid[0], value_valid[1], overflow[2]
  logic        m_axis_tlast;

  codec_xfer_t codec_results_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          steady_run = 1'b0;
  bit          hold_off_req = 1'b0;

  // decoder state of the model
  logic [3:0]  dec_left = '0;
  logic [3:0]  dec_len = '0;
  logic        dec_sgn = 1'b0;
  logic [63:0] dec_acc = '0;

  prefix_varint_codec i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offset removed from unsigned values coded in n bytes
  function automatic logic [63:0] len_base(input int n);
    if (n >= 9) return pvc_pkg::SumOffset;
    return pvc_pkg::SumOffset & ((64'd1 << (7 * (n - 1) + 1)) - 64'd1);
  endfunction

  function automatic codec_xfer_t byte_xfer(input logic [7:0] b, input logic lst);
    return '{b, 1'b1, 64'd0, 1'b0, 1'b0, lst};
  endfunction

  function automatic codec_xfer_t value_xfer(input logic [63:0] v, input logic wrap);
    return '{8'h00, 1'b0, v, 1'b1, wrap, 1'b1};
  endfunction

  // full code of a value, first byte on the wire in bits [7:0]
  function automatic logic [71:0] prefix_code(input logic sgn, input logic [63:0] v,
                                              output int len);
    logic [63:0] mag;
    logic [63:0] word;
    logic [63:0] raw;
    int n;
    prefix_code = '0;
    word = '0;
    len = 9;
    mag = v[63] ? ~v : v;
    for (n = 1; n <= 8; n++) begin
      if (len == 9 && (sgn ? (mag < (64'd1 << (7 * n - 1))) : (v < len_base(n + 1)))) begin
        if (sgn) begin
          word = (v & ((64'd1 << (7 * n)) - 64'd1)) | (64'd1 << (7 * n));
        end else begin
          word = (v - len_base(n)) | (64'd1 << (7 * n));
        end
        len = n;
      end
    end
    if (len == 9) begin
      // zero first byte, then the raw word big-endian
      raw = sgn ? v : v - pvc_pkg::SumOffset;
      for (n = 1; n <= 8; n++) prefix_code[8*n +: 8] = raw[8*(8-n) +: 8];
    end else begin
      for (n = 0; n < len; n++) prefix_code[8*n +: 8] = word[8*(len-1-n) +: 8];
    end
  endfunction

  task automatic decode_step(input logic sgn, input logic [7:0] b);
    logic [63:0] mask;
    logic [63:0] res;
    logic        wrap;
    int n;
    int w;
    if (dec_left == 0) begin
      // signedness is fixed by the first byte of a code
      dec_sgn = sgn;
      n = 1;
      if (b == 8'h00) begin
        n = 9;
        dec_acc = '0;
      end else begin
        while (!b[8-n]) n++;
        dec_acc = {56'd0, b} & ((64'd1 << (8 - n)) - 64'd1);
      end
      dec_len = 4'(n);
      dec_left = 4'(n - 1);
    end else begin
      dec_acc = {dec_acc[55:0], b};
      dec_left = dec_left - 4'd1;
    end
    if (dec_left == 0) begin
      n = int'(dec_len);
      wrap = 1'b0;
      if (n >= 9) begin
        res = dec_sgn ? dec_acc : dec_acc + pvc_pkg::SumOffset;
        wrap = !dec_sgn && (res < pvc_pkg::SumOffset);
      end else if (dec_sgn) begin
        w = 7 * n;
        mask = (64'd1 << w) - 64'd1;
        res = dec_acc & mask;
        if (res[w-1]) res = res | ~mask;
      end else begin
        res = dec_acc + len_base(n);
      end
      codec_results_q.push_back(value_xfer(res, wrap));
    end
  endtask

  task automatic varint_step(input pvc_pkg::pvc_op_e op, input logic [63:0] v,
                             input logic [7:0] b);
    logic [71:0] code;
    int len;
    int i;
    case (op)
      pvc_pkg::OP_ENC_U, pvc_pkg::OP_ENC_S: begin
        code = prefix_code(op == pvc_pkg::OP_ENC_S, v, len);
        for (i = 0; i < len; i++) begin
          codec_results_q.push_back(byte_xfer(code[8*i +: 8], i == len - 1));
        end
      end
      default: decode_step(op == pvc_pkg::OP_DEC_S, b);
    endcase
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    int m;
    r = {$urandom, $urandom};
    m = $urandom_range(1, 9);
    case ($urandom_range(0, 4))
      0: return r;
      1: return r >> $urandom_range(0, 63);
      2: return ~(r >> $urandom_range(0, 63));
      3: return len_base(m) - {62'd0, r[1:0]};
      default: begin
        // largest or smallest signed value of an m-byte code
        if (m == 9) return {r[0], {63{~r[0]}}};
        return ((64'd1 << (7 * m - 1)) - 64'd1) ^ {64{r[0]}};
      end
    endcase
  endfunction

  task automatic send_item(input pvc_pkg::pvc_op_e op, input logic [63:0] v,
                           input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!steady_run && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 16);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, v};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    varint_step(op, v, b);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (codec_results_q.size() != 0);
  endtask

  // stimulus
  initial begin : source
    stim_row_t        dir_rows[$];
    stim_row_t        row;
    logic [71:0]      code;
    pvc_pkg::pvc_op_e first_op;
    int unsigned      rand_goal;
    int len;
    int cut;
    int i;
    bit hold_done;
    bit pause_done;

    dir_rows.push_back('{pvc_pkg::OP_ENC_U, 64'd0, 8'h00, 1'b1, byte_xfer(8'h80, 1'b1)});
    dir_rows.push_back('{pvc_pkg::OP_ENC_U, 64'd127, 8'hFF, 1'b1, byte_xfer(8'hFF, 1'b1)});
    dir_rows.push_back('{pvc_pkg::OP_ENC_U, 64'd128, 8'h00, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_ENC_U, pvc_pkg::SumOffset, 8'hFF, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_ENC_U, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_ENC_S, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1,
                         byte_xfer(8'hFF, 1'b1)});
    dir_rows.push_back('{pvc_pkg::OP_ENC_S, 64'd63, 8'h00, 1'b1, byte_xfer(8'hBF, 1'b1)});
    dir_rows.push_back('{pvc_pkg::OP_ENC_S, 64'hFFFF_FFFF_FFFF_FFC0, 8'h00, 1'b1,
                         byte_xfer(8'hC0, 1'b1)});
    dir_rows.push_back('{pvc_pkg::OP_ENC_S, 64'h8000_0000_0000_0000, 8'h00, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_ENC_S, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_DEC_U, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 1'b1,
                         value_xfer(64'd0, 1'b0)});
    dir_rows.push_back('{pvc_pkg::OP_DEC_S, 64'd0, 8'hC0, 1'b1,
                         value_xfer(64'hFFFF_FFFF_FFFF_FFC0, 1'b0)});
    // nine-byte unsigned code that wraps, continued under both decode opcodes
    // and with an encode in the middle
    dir_rows.push_back('{pvc_pkg::OP_DEC_U, 64'd0, 8'h00, 1'b0, '0});
    for (i = 0; i < 4; i++) begin
      dir_rows.push_back('{pvc_pkg::OP_DEC_S, 64'd0, 8'hFF, 1'b0, '0});
    end
    dir_rows.push_back('{pvc_pkg::OP_ENC_U, pvc_pkg::SumOffset - 64'd1, 8'h00, 1'b0, '0});
    for (i = 0; i < 3; i++) begin
      dir_rows.push_back('{pvc_pkg::OP_DEC_U, 64'd0, 8'hFF, 1'b0, '0});
    end
    dir_rows.push_back('{pvc_pkg::OP_DEC_S, 64'd0, 8'hFF, 1'b1,
                         value_xfer(pvc_pkg::SumOffset - 64'd1, 1'b1)});
    // two-byte signed code finished under the unsigned opcode
    dir_rows.push_back('{pvc_pkg::OP_DEC_S, 64'd0, 8'h7F, 1'b0, '0});
    dir_rows.push_back('{pvc_pkg::OP_DEC_U, 64'd0, 8'hFF, 1'b1,
                         value_xfer(64'hFFFF_FFFF_FFFF_FFFF, 1'b0)});

    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_item(row.op, row.value, row.din);
      if (row.typed) begin
        void'(codec_results_q.pop_back());
        codec_results_q.push_back(row.want);
      end
    end
    wait_drained();

    rand_goal = items_sent + RandItems;
    while (items_sent < rand_goal) begin
      steady_run = (items_sent >= 80 && items_sent < 130);
      if (!hold_done && items_sent >= 150) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= 220) begin
        wait_drained();
        pause_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          send_item(pvc_pkg::pvc_op_e'($urandom_range(0, 1)), pick_value(), 8'($urandom));
        end
        17, 18, 19: begin
          send_item(pvc_pkg::pvc_op_e'($urandom_range(2, 3)), {$urandom, $urandom},
                    8'($urandom));
        end
        default: begin
          // well-formed code, now and then cut short
          code = prefix_code(1'($urandom_range(0, 1)), pick_value(), len);
          cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
          first_op = pvc_pkg::pvc_op_e'($urandom_range(2, 3));
          for (i = 0; i < cut; i++) begin
            if (i != 0 && $urandom_range(0, 7) == 0) begin
              send_item(pvc_pkg::pvc_op_e'($urandom_range(0, 1)), pick_value(),
                        8'($urandom));
            end
            send_item((i == 0) ? first_op : pvc_pkg::pvc_op_e'($urandom_range(2, 3)),
                      {$urandom, $urandom}, code[8*i +: 8]);
          end
        end
      endcase
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: rotating stall pattern, free-running stretches, one long hold-off
  initial begin : sink
    logic [7:0]  stall_pat;
    int unsigned tick;
    bit          free_run;
    stall_pat = 8'hFF;
    tick = 0;
    free_run = 1'b1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= free_run | stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        tick++;
        if (tick % 48 == 0) begin
          stall_pat = 8'($urandom) | 8'h01;
          free_run = ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    codec_xfer_t seen;
    codec_xfer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[71:8],
               m_axis_tuser[1], m_axis_tuser[2], m_axis_tlast};
      if (codec_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected transfer: byte %h/%b value %h/%b ovf %b last %b",
                   seen.code_byte, seen.byte_ok, seen.value, seen.value_ok,
                   seen.wrapped, seen.final_xfer);
        end
      end else begin
        want = codec_results_q.pop_front();
        if (seen.code_byte !== want.code_byte || seen.byte_ok !== want.byte_ok ||
            seen.value !== want.value || seen.value_ok !== want.value_ok ||
            seen.wrapped !== want.wrapped || seen.final_xfer !== want.final_xfer) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp byte %h/%b value %h/%b ovf %b last %b",
                     want.code_byte, want.byte_ok, want.value, want.value_ok,
                     want.wrapped, want.final_xfer);
            $display("          got byte %h/%b value %h/%b ovf %b last %b",
                     seen.code_byte, seen.byte_ok, seen.value, seen.value_ok,
                     seen.wrapped, seen.final_xfer);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
